// ===== rtl/gbs_pkg.sv =====
// gbs_pkg: shared types and constants for the grid bilinear sampler.
// Used by the cfg channel interface, the shared divider and the top level.
package gbs_pkg;

    localparam int ONE_Q16    = 65536;
    localparam int DIV_NW     = 64;   // dividend bits, one per divider step
    localparam int DIV_DW     = 40;   // divisor / remainder bits
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LON_ORIGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_ORIGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LON_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_STEP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LON_WRAP   = 3'd6;

    // item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
        logic [DIV_DW-1:0] rem;
    } div_rsp_t;

endpackage

// ===== rtl/gbs_req_if.sv =====
// gbs_req_if: input item channel (cell writes and sample queries).
// Depends on nothing.
interface gbs_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [3:0]  field_number;
    logic [6:0]         col;
    logic [6:0]         row;
    logic signed [31:0] cell_value;
    logic               cell_present;
    logic signed [23:0] lat;
    logic signed [26:0] lon;

    modport source (output valid, cmd, field_number, col, row, cell_value, cell_present,
                    lat, lon, input ready);
    modport sink   (input valid, cmd, field_number, col, row, cell_value, cell_present,
                    lat, lon, output ready);
endinterface

// ===== rtl/gbs_rsp_if.sv =====
// gbs_rsp_if: result item channel.
// Depends on nothing.
interface gbs_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               valid_res;

    modport source (output valid, value, valid_res, input ready);
    modport sink   (input valid, value, valid_res, output ready);
endinterface

// ===== rtl/gbs_cfg_if.sv =====
// gbs_cfg_if: register write channel.
// Depends on gbs_pkg for widths.
interface gbs_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gbs_pkg::CFG_IDX_W-1:0]      index;
    logic [gbs_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/grid_bilinear_sampler_top.sv =====
// grid_bilinear_sampler_top: missing-aware bilinear sampler over stored lat/lon grids.
// Depends on gbs_pkg, gbs_req_if, gbs_rsp_if, gbs_cfg_if, gbs_ram, gbs_div.
//
//   channel | dir | handshake   | payload
//   req     | in  | valid/ready | cmd, field_number, col, row, cell_value, cell_present, lat, lon
//   rsp     | out | valid/ready | value, valid_res
//   cfg     | in  | valid/ready | index, data (ready always high)
//
// A cell write goes to the store as it is taken. A query runs four divider passes (start,
// quotient steps, done) for longitude wrap, column, row and weighted mean, plus span,
// position, four weight steps and a read, multiply and accumulate step per corner; the next
// item is taken once its result has moved to the output register.
// An absent field or zero step goes straight to the result; all weights missing skips the mean pass.
// After reset the grid store is cleared, one entry per cycle, over all
// FIELD_COUNT*GRID_ROWS_MAX*GRID_COLS_MAX entries; req is not ready meanwhile.
// A finished result waits in the output register; the next item is taken meanwhile.
module grid_bilinear_sampler_top #(
    parameter int FIELD_COUNT   = 8,
    parameter int GRID_COLS_MAX = 128,
    parameter int GRID_ROWS_MAX = 128
) (
    input  logic      clk,
    input  logic      rst_n,
    gbs_req_if.sink   req,
    gbs_rsp_if.source rsp,
    gbs_cfg_if.sink   cfg
);
    import gbs_pkg::*;

    localparam int DEPTH = FIELD_COUNT * GRID_ROWS_MAX * GRID_COLS_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int CIW   = $clog2(GRID_COLS_MAX);
    localparam int RIW   = $clog2(GRID_ROWS_MAX);
    localparam int NXW   = $clog2(GRID_COLS_MAX + 1);
    localparam int NYW   = $clog2(GRID_ROWS_MAX + 1);
    localparam int FW    = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1;

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_SPAN  = 5'd2;
    localparam logic [4:0] S_MOD   = 5'd3;
    localparam logic [4:0] S_MODW  = 5'd4;
    localparam logic [4:0] S_FI    = 5'd5;
    localparam logic [4:0] S_FIW   = 5'd6;
    localparam logic [4:0] S_FJ    = 5'd7;
    localparam logic [4:0] S_FJW   = 5'd8;
    localparam logic [4:0] S_POS   = 5'd9;
    localparam logic [4:0] S_WGT   = 5'd10;
    localparam logic [4:0] S_RADDR = 5'd11;
    localparam logic [4:0] S_RMUL  = 5'd12;
    localparam logic [4:0] S_RACC  = 5'd13;
    localparam logic [4:0] S_FIN   = 5'd14;
    localparam logic [4:0] S_FINW  = 5'd15;
    localparam logic [4:0] S_DONE  = 5'd16;

    // configuration
    logic [7:0]         cols_reg, rows_reg;
    logic signed [25:0] lon_org_reg;
    logic signed [23:0] lat_org_reg;
    logic [22:0]        lon_step_reg;
    logic signed [23:0] lat_step_reg;
    logic               wrap_reg;

    logic [4:0]         state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [1:0]         k_reg, k_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic               out_ok_reg, out_ok_next;

    logic [FW-1:0]      fld_reg, fld_next;
    logic signed [23:0] lat_q_reg, lat_q_next;
    logic signed [26:0] lon_q_reg, lon_q_next;
    logic [DIV_DW-1:0]  span_reg, span_next;
    logic [DIV_DW-1:0]  rel_reg, rel_next;
    logic [CIW-1:0]     i0_reg, i0_next, i1_reg, i1_next;
    logic [15:0]        tc_reg, tc_next;
    logic [RIW-1:0]     j0_reg, j0_next;
    logic [16:0]        tr_reg, tr_next;
    logic [16:0]        w_reg [4];
    logic [16:0]        w_next;
    logic signed [49:0] prod_reg, prod_next;
    logic               pres_reg, pres_next;
    logic signed [51:0] sum_reg, sum_next;
    logic [18:0]        wsum_reg, wsum_next;
    logic signed [31:0] res_val_reg, res_val_next;
    logic               res_ok_reg, res_ok_next;

    logic [NXW-1:0]     nx;
    logic [NYW-1:0]     ny;
    logic               accept, fld_ok, wr_ok;
    logic signed [27:0] lon_diff;
    logic [27:0]        lon_mag;
    logic signed [24:0] lat_diff;
    logic [24:0]        lat_mag;
    logic [23:0]        lat_step_mag;
    logic               fj_neg;
    logic [42:0]        fj_c, fj_max;
    logic [42:0]        j0_full;
    logic [16:0]        wa, wb;
    logic [33:0]        wprod;
    logic signed [53:0] mean_num;
    logic [53:0]        mean_mag;
    logic [54:0]        vmag;
    logic [CIW-1:0]     ci;
    logic [RIW-1:0]     cj;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [32:0]        ram_wdata, ram_rdata;
    div_req_t           dreq;
    div_rsp_t           drsp;

    gbs_ram #(.WIDTH(33), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gbs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.value     = out_value_reg;
    assign rsp.valid_res = out_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg     <= 8'd128;
            rows_reg     <= 8'd128;
            lon_org_reg  <= '0;
            lat_org_reg  <= '0;
            lon_step_reg <= 23'd65536;
            lat_step_reg <= 24'sd65536;
            wrap_reg     <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_GRID_COLS:  cols_reg     <= cfg.data[7:0];
                CFG_GRID_ROWS:  rows_reg     <= cfg.data[7:0];
                CFG_LON_ORIGIN: lon_org_reg  <= cfg.data[25:0];
                CFG_LAT_ORIGIN: lat_org_reg  <= cfg.data[23:0];
                CFG_LON_STEP:   lon_step_reg <= cfg.data[22:0];
                CFG_LAT_STEP:   lat_step_reg <= cfg.data[23:0];
                CFG_LON_WRAP:   wrap_reg     <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // effective grid size
    always_comb
    begin
        if (32'(cols_reg) > GRID_COLS_MAX)
            nx = NXW'(GRID_COLS_MAX);
        else if (cols_reg < 8'd2)
            nx = NXW'(2);
        else
            nx = NXW'(cols_reg);
        if (32'(rows_reg) > GRID_ROWS_MAX)
            ny = NYW'(GRID_ROWS_MAX);
        else if (rows_reg < 8'd2)
            ny = NYW'(2);
        else
            ny = NYW'(rows_reg);
    end

    assign fld_ok = !req.field_number[3] && (32'(req.field_number[2:0]) < FIELD_COUNT);
    assign wr_ok  = fld_ok && (32'(req.col) < GRID_COLS_MAX) && (32'(req.row) < GRID_ROWS_MAX);

    assign lon_diff     = {lon_q_reg[26], lon_q_reg} - {{2{lon_org_reg[25]}}, lon_org_reg};
    assign lon_mag      = lon_diff[27] ? 28'(-lon_diff) : 28'(lon_diff);
    assign lat_diff     = {lat_q_reg[23], lat_q_reg} - {lat_org_reg[23], lat_org_reg};
    assign lat_mag      = lat_diff[24] ? 25'(-lat_diff) : 25'(lat_diff);
    assign lat_step_mag = lat_step_reg[23] ? 24'(-lat_step_reg) : 24'(lat_step_reg);
    assign fj_neg       = lat_diff[24] ^ lat_step_reg[23];

    // corner k: bit 0 picks the right column, bit 1 the upper row
    assign ci = k_reg[0] ? i1_reg : i0_reg;
    assign cj = k_reg[1] ? RIW'(j0_reg + 1'b1) : j0_reg;
    assign wa = k_reg[0] ? {1'b0, tc_reg} : 17'(ONE_Q16 - 32'(tc_reg));
    assign wb = k_reg[1] ? tr_reg : 17'(ONE_Q16 - 32'(tr_reg));

    assign mean_num = {sum_reg[51], sum_reg, 1'b0} + 54'(wsum_reg);
    assign mean_mag = mean_num[53] ? 54'(-mean_num) : 54'(mean_num);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_value_next = out_value_reg;
        out_ok_next    = out_ok_reg;
        fld_next       = fld_reg;
        lat_q_next     = lat_q_reg;
        lon_q_next     = lon_q_reg;
        span_next      = span_reg;
        rel_next       = rel_reg;
        i0_next        = i0_reg;
        i1_next        = i1_reg;
        tc_next        = tc_reg;
        j0_next        = j0_reg;
        tr_next        = tr_reg;
        w_next         = '0;
        prod_next      = prod_reg;
        pres_next      = pres_reg;
        sum_next       = sum_reg;
        wsum_next      = wsum_reg;
        res_val_next   = res_val_reg;
        res_ok_next    = res_ok_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'((32'(req.field_number[2:0]) * GRID_ROWS_MAX + 32'(req.row))
                             * GRID_COLS_MAX + 32'(req.col));
        ram_wdata      = {req.cell_present, req.cell_value};
        ram_re         = 1'b0;
        ram_raddr      = AW'((32'(fld_reg) * GRID_ROWS_MAX + 32'(cj)) * GRID_COLS_MAX
                             + 32'(ci));
        dreq.start     = 1'b0;
        dreq.num       = '0;
        dreq.den       = span_reg;
        fj_c           = '0;
        fj_max         = 43'(ny - 1'b1) << 16;
        j0_full        = '0;
        wprod          = wa * wb;
        vmag           = {1'b0, drsp.quo[53:0]} + 55'(drsp.rem != '0);

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == CMD_WRITE)
                    begin
                        ram_we = wr_ok;
                    end
                    else
                    begin
                        fld_next   = FW'(req.field_number[2:0]);
                        lat_q_next = req.lat;
                        lon_q_next = req.lon;
                        sum_next   = '0;
                        wsum_next  = '0;
                        k_next     = '0;
                        if (!fld_ok || lon_step_reg == '0 || lat_step_reg == '0)
                        begin
                            res_val_next = '0;
                            res_ok_next  = 1'b0;
                            state_next   = S_DONE;
                        end
                        else
                            state_next = S_SPAN;
                    end
                end
            end
            S_SPAN:
            begin
                span_next  = DIV_DW'(nx) * DIV_DW'(lon_step_reg);
                state_next = S_MOD;
            end
            S_MOD:
            begin
                dreq.start = 1'b1;
                dreq.num   = DIV_NW'(lon_mag);
                dreq.den   = span_reg;
                state_next = S_MODW;
            end
            S_MODW:
            begin
                if (drsp.done)
                begin
                    if (lon_diff[27] && drsp.rem != '0)
                        rel_next = span_reg - drsp.rem;
                    else if (lon_diff[27])
                        rel_next = '0;
                    else
                        rel_next = drsp.rem;
                    state_next = S_FI;
                end
            end
            S_FI:
            begin
                dreq.start = 1'b1;
                dreq.num   = DIV_NW'(rel_reg) << 16;
                dreq.den   = DIV_DW'(lon_step_reg);
                state_next = S_FIW;
            end
            S_FIW:
            begin
                if (drsp.done)
                begin
                    i0_next    = drsp.quo[16 +: CIW];
                    tc_next    = drsp.quo[15:0];
                    state_next = S_FJ;
                end
            end
            S_FJ:
            begin
                dreq.start = 1'b1;
                dreq.num   = DIV_NW'(lat_mag) << 16;
                dreq.den   = DIV_DW'(lat_step_mag);
                state_next = S_FJW;
            end
            S_FJW:
            begin
                if (drsp.done)
                    state_next = S_POS;
            end
            S_POS:
            begin
                // a negative row position clamps to zero
                if (fj_neg)
                    fj_c = '0;
                else if (drsp.quo[42:0] > fj_max)
                    fj_c = fj_max;
                else
                    fj_c = drsp.quo[42:0];
                j0_full = fj_c >> 16;
                if (j0_full > 43'(ny - 2'd2))
                    j0_full = 43'(ny - 2'd2);
                j0_next = RIW'(j0_full);
                tr_next = 17'(fj_c - (j0_full << 16));
                if (wrap_reg)
                begin
                    i1_next = (32'(i0_reg) == 32'(nx) - 1) ? '0 : CIW'(i0_reg + 1'b1);
                end
                else
                begin
                    if (32'(i0_reg) > 32'(nx) - 2)
                        i0_next = CIW'(nx - 2'd2);
                    i1_next = CIW'(i0_next + 1'b1);
                end
                k_next     = '0;
                state_next = S_WGT;
            end
            S_WGT:
            begin
                w_next = wprod[32:16];
                k_next = k_reg + 1'b1;
                if (k_reg == 2'd3)
                    state_next = S_RADDR;
            end
            S_RADDR:
            begin
                ram_re     = 1'b1;
                state_next = S_RMUL;
            end
            S_RMUL:
            begin
                prod_next  = $signed(ram_rdata[31:0]) * $signed({1'b0, w_reg[k_reg]});
                pres_next  = ram_rdata[32];
                state_next = S_RACC;
            end
            S_RACC:
            begin
                if (pres_reg)
                begin
                    sum_next  = sum_reg + 52'(prod_reg);
                    wsum_next = wsum_reg + 19'(w_reg[k_reg]);
                end
                k_next = k_reg + 1'b1;
                if (k_reg == 2'd3)
                    state_next = S_FIN;
                else
                    state_next = S_RADDR;
            end
            S_FIN:
            begin
                if (wsum_reg == '0)
                begin
                    res_val_next = '0;
                    res_ok_next  = 1'b0;
                    state_next   = S_DONE;
                end
                else
                begin
                    dreq.start = 1'b1;
                    dreq.num   = DIV_NW'(mean_mag);
                    dreq.den   = DIV_DW'({wsum_reg, 1'b0});
                    state_next = S_FINW;
                end
            end
            S_FINW:
            begin
                if (drsp.done)
                begin
                    // floor division: a negative quotient with remainder steps down
                    res_ok_next = 1'b1;
                    if (mean_num[53])
                    begin
                        if (vmag > 55'h80000000)
                            res_val_next = 32'sh80000000;
                        else
                            res_val_next = 32'(-vmag);
                    end
                    else
                    begin
                        if (drsp.quo[53:0] > 54'h7FFFFFFF)
                            res_val_next = 32'sh7FFFFFFF;
                        else
                            res_val_next = drsp.quo[31:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_val_reg;
                    out_ok_next    = res_ok_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_ok_reg    <= out_ok_next;
        fld_reg       <= fld_next;
        lat_q_reg     <= lat_q_next;
        lon_q_reg     <= lon_q_next;
        span_reg      <= span_next;
        rel_reg       <= rel_next;
        i0_reg        <= i0_next;
        i1_reg        <= i1_next;
        tc_reg        <= tc_next;
        j0_reg        <= j0_next;
        tr_reg        <= tr_next;
        prod_reg      <= prod_next;
        pres_reg      <= pres_next;
        sum_reg       <= sum_next;
        wsum_reg      <= wsum_next;
        res_val_reg   <= res_val_next;
        res_ok_reg    <= res_ok_next;
        if (state_reg == S_WGT)
            w_reg[k_reg] <= w_next;
    end

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg == S_MODW || state_reg == S_FIW
                       || state_reg == S_FJW || state_reg == S_FINW))
        else $error("divider result with no step waiting for it");
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_valid_reg && !rsp.ready |=> state_reg == S_DONE)
        else $error("result dropped while output slot busy");
    a_read_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RADDR |=> state_reg == S_RMUL)
        else $error("corner read not followed by multiply");
    a_clear_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !req.ready)
        else $error("item taken during store clear");
endmodule

// ===== rtl/gbs_ram.sv =====
// gbs_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module gbs_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 131072
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/gbs_div.sv =====
// gbs_div: shared restoring divider, one quotient bit per cycle.
// Depends on gbs_pkg (div_req_t, div_rsp_t, DIV_NW, DIV_DW).
module gbs_div (
    input  logic              clk,
    input  logic              rst_n,
    input  gbs_pkg::div_req_t req,
    output gbs_pkg::div_rsp_t rsp
);
    import gbs_pkg::*;

    localparam int CW = $clog2(DIV_NW);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DIV_NW-1:0] num_reg, num_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, num_reg[DIV_NW-1]};
        diff      = trial - {1'b0, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = req.num;
            den_next  = req.den;
            quo_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DIV_NW-2:0], 1'b0};
            if (!diff[DIV_DW])
            begin
                rem_next = diff[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider finished without running");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !req.start |=> busy_reg || done_reg)
        else $error("divider stopped without done");
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < den_reg)
        else $error("remainder not below divisor");
endmodule

// ===== dv/grid_bilinear_sampler_top_tb.sv =====
// Testbench for grid_bilinear_sampler_top: cell writes, sample queries, register phases.
// Depends on gbs_pkg and the gbs_req_if, gbs_rsp_if and gbs_cfg_if interfaces.
module grid_bilinear_sampler_top_tb;
    import gbs_pkg::*;

    localparam int NF = 8;
    localparam int NC = 128;
    localparam int NR = 128;

    typedef struct {
        logic signed [31:0] value;
        logic               valid_res;
    } sample_t;

    // shadow of the grids and registers; predicts each query's sample
    class sample_board;
        logic [32:0]        cells [int];
        logic [7:0]         cols, rows;
        logic signed [25:0] lon_org;
        logic signed [23:0] lat_org;
        logic [22:0]        lon_stp;
        logic signed [23:0] lat_stp;
        logic               wrap;
        sample_t            pending [$];
        int                 errors;

        function void clear();
            cells.delete();
            cols = 128; rows = 128; lon_org = 0; lat_org = 0;
            lon_stp = 23'd65536; lat_stp = 24'sd65536; wrap = 0;
            pending.delete();
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
            case (idx)
                CFG_GRID_COLS:  cols = d[7:0];
                CFG_GRID_ROWS:  rows = d[7:0];
                CFG_LON_ORIGIN: lon_org = d[25:0];
                CFG_LAT_ORIGIN: lat_org = d[23:0];
                CFG_LON_STEP:   lon_stp = d[22:0];
                CFG_LAT_STEP:   lat_stp = d[23:0];
                CFG_LON_WRAP:   wrap = d[0];
                default: ;
            endcase
        endfunction

        function longint fdiv(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b != 0) && ((a < 0) != (b < 0))) q -= 1;
            return q;
        endfunction

        function logic [32:0] cell_at(int f, longint r, longint c);
            int key;
            key = (f * NR + int'(r)) * NC + int'(c);
            return cells.exists(key) ? cells[key] : 33'd0;
        endfunction

        function void note_item(logic cmd, logic signed [3:0] fld, logic [6:0] c,
                                logic [6:0] r, logic [31:0] v, logic p,
                                logic signed [23:0] la, logic signed [26:0] lo);
            longint nx, ny, dlon, dlat, span, rel, fi, i0, i1, tc, fj, j0, tr;
            longint w [4];
            longint ci [4];
            longint cj [4];
            longint s, ws, q;
            logic [32:0] e;
            sample_t res;
            if (cmd == CMD_WRITE) begin
                if (fld >= 0 && fld < NF) cells[(int'(fld) * NR + r) * NC + c] = {p, v};
                return;
            end
            res.value = 0; res.valid_res = 0;
            nx = cols; ny = rows;
            if (nx < 2) nx = 2;
            if (nx > NC) nx = NC;
            if (ny < 2) ny = 2;
            if (ny > NR) ny = NR;
            dlon = lon_stp; dlat = lat_stp;
            if (fld < 0 || fld >= NF || dlon == 0 || dlat == 0) begin
                pending.push_back(res);
                return;
            end
            span = nx * dlon;
            rel = (longint'(lo) - longint'(lon_org)) % span;
            if (rel < 0) rel += span;
            fi = (rel * 65536) / dlon;
            i0 = fi / 65536; tc = fi % 65536;
            if (wrap) begin
                i0 = i0 % nx; i1 = (i0 + 1) % nx;
            end else begin
                if (i0 > nx - 2) i0 = nx - 2;
                i1 = i0 + 1;
            end
            fj = fdiv((longint'(la) - longint'(lat_org)) * 65536, dlat);
            if (fj < 0) fj = 0;
            if (fj > (ny - 1) * 65536) fj = (ny - 1) * 65536;
            j0 = fj / 65536;
            if (j0 > ny - 2) j0 = ny - 2;
            tr = fj - j0 * 65536;
            ci = '{i0, i1, i0, i1};
            cj = '{j0, j0, j0 + 1, j0 + 1};
            w[0] = ((65536 - tc) * (65536 - tr)) / 65536;
            w[1] = (tc * (65536 - tr)) / 65536;
            w[2] = ((65536 - tc) * tr) / 65536;
            w[3] = (tc * tr) / 65536;
            s = 0; ws = 0;
            for (int k = 0; k < 4; k++) begin
                e = cell_at(fld, cj[k], ci[k]);
                if (e[32]) begin
                    s += longint'($signed(e[31:0])) * w[k];
                    ws += w[k];
                end
            end
            if (ws > 0) begin
                q = fdiv(2 * s + ws, 2 * ws);
                if (q > 64'sd2147483647) q = 64'sd2147483647;
                if (q < -64'sd2147483648) q = -64'sd2147483648;
                res.value = q[31:0];
                res.valid_res = 1;
            end
            pending.push_back(res);
        endfunction

        function void check_sample(logic signed [31:0] v, logic vr);
            sample_t x;
            if (pending.size() == 0) begin
                $display("%0t: unexpected sample value=%0d valid_res=%0b", $time, v, vr);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (v !== x.value) begin
                $display("%0t: value expected %0d actual %0d", $time, x.value, v);
                errors++;
            end
            if (vr !== x.valid_res) begin
                $display("%0t: valid_res expected %0b actual %0b", $time, x.valid_res, vr);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    bit   calm = 0;
    sample_board board;

    gbs_req_if req ();
    gbs_rsp_if rsp ();
    gbs_cfg_if cfg ();

    grid_bilinear_sampler_top dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg));

    always #5 clk = ~clk;

    initial
    begin
        req.valid = 0; req.cmd = 0; req.field_number = 0; req.col = 0; req.row = 0;
        req.cell_value = 0; req.cell_present = 0; req.lat = 0; req.lon = 0;
        cfg.valid = 0; cfg.index = 0; cfg.data = 0;
        rsp.ready = 0;
    end

    // result side: random stall bursts, checks at each accepted item
    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready) board.check_sample(rsp.value, rsp.valid_res);
            if (n > 0) n--;
            else if (!calm && $urandom_range(0, 7) == 0) n = $urandom_range(1, 14);
            rsp.ready <= (n == 0);
        end
    end

    // valid stays high after an accept; the next task call in the same step drops or reuses it
    task automatic send_item(logic cmd, logic signed [3:0] fld, logic [6:0] c, logic [6:0] r,
                             logic [31:0] v, logic p, logic signed [23:0] la,
                             logic signed [26:0] lo);
        cfg.valid <= 0;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            req.valid <= 0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req.valid <= 1; req.cmd <= cmd; req.field_number <= fld; req.col <= c; req.row <= r;
        req.cell_value <= v; req.cell_present <= p; req.lat <= la; req.lon <= lo;
        do @(posedge clk); while (!req.ready);
        board.note_item(cmd, fld, c, r, v, p, la, lo);
    endtask

    task automatic put_cell(int f, int c, int r, logic [31:0] v, logic p);
        send_item(CMD_WRITE, 4'(f), 7'(c), 7'(r), v, p, '0, '0);
    endtask

    task automatic ask(int f, logic signed [23:0] la, logic signed [26:0] lo);
        send_item(CMD_QUERY, 4'(f), 7'($urandom), 7'($urandom), $urandom, 1'($urandom),
                  la, lo);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        cfg.valid <= 1; cfg.index <= idx; cfg.data <= d;
        do @(posedge clk); while (!cfg.ready);
        board.set_reg(idx, d);
    endtask

    task automatic drain();
        req.valid <= 0;
        cfg.valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // random query position near the current grid, sometimes anywhere
    task automatic rand_query(int f);
        longint la, lo;
        if ($urandom_range(0, 4) == 0) begin
            la = $signed($urandom_range(0, 11796480)) - 5898240;
            lo = $signed($urandom_range(0, 94371840)) - 47185920;
        end else begin
            la = longint'(board.lat_org) + longint'(board.lat_stp) *
                 $urandom_range(0, board.rows) + $signed($urandom_range(0, 131072)) - 65536;
            lo = longint'(board.lon_org) + longint'(board.lon_stp) *
                 $urandom_range(0, board.cols) + $signed($urandom_range(0, 131072)) - 65536;
            if (la > 5898240) la = 5898240;
            if (la < -5898240) la = -5898240;
            if (lo > 47185920) lo = 47185920;
            if (lo < -47185920) lo = -47185920;
        end
        ask(f, 24'(la), 27'(lo));
    endtask

    task automatic rand_phase(int items, int nc, int nr);
        int f;
        for (int k = 0; k < items; k++)
        begin
            f = $urandom_range(0, 3);
            if ($urandom_range(0, 19) == 0) f = $signed($urandom_range(0, 15)) - 8;
            if ($urandom_range(0, 1) == 0)
                put_cell(f, $urandom_range(0, nc - 1), $urandom_range(0, nr - 1),
                         $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 22),
                         $urandom_range(0, 4) != 0);
            else
                rand_query(f);
        end
    endtask

    initial
    begin
        board = new();
        board.clear();
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: small 4x3 grid in field 0, extremes in field 7
        set_reg(CFG_GRID_COLS, 4);
        set_reg(CFG_GRID_ROWS, 3);
        put_cell(0, 0, 0, 32'h7FFF_FFFF, 1);
        put_cell(0, 1, 0, 32'h8000_0000, 1);
        put_cell(0, 0, 1, 32'h0001_0000, 1);
        put_cell(0, 1, 1, 32'h0003_0000, 0);
        put_cell(0, 3, 2, 32'hFFFE_0000, 1);
        put_cell(7, 127, 127, 32'h1234_5678, 1);
        put_cell(-1, 5, 5, 32'h1, 1);
        ask(0, 0, 0);
        ask(0, 24'sd32768, 27'sd32768);
        ask(0, 24'sd65536, 27'sd65536);
        ask(0, -24'sd5898240, -27'sd47185920);
        ask(0, 24'sd5898240, 27'sd47185920);
        ask(0, 24'sd100000, 27'sd250000);
        ask(-1, 0, 0);
        ask(7, 0, 0);
        ask(5, 0, 0);
        drain();
        set_reg(CFG_LON_WRAP, 1);
        ask(0, 24'sd131072, 27'sd229376);
        ask(0, 0, -27'sd16384);
        drain();
        set_reg(CFG_LAT_STEP, 0);
        ask(0, 0, 0);
        drain();
        set_reg(CFG_LAT_STEP, -24'sd65536);
        set_reg(CFG_LAT_ORIGIN, 24'sd131072);
        ask(0, 24'sd65536, 27'sd32768);
        drain();

        // random phases across register settings, extremes among them
        for (int ph = 0; ph < 8; ph++)
        begin
            int nc, nr;
            case (ph)
                0: begin nc = 2;   nr = 2;   end
                1: begin nc = 128; nr = 128; end
                default: begin nc = $urandom_range(2, 12); nr = $urandom_range(2, 12); end
            endcase
            set_reg(CFG_GRID_COLS, nc);
            set_reg(CFG_GRID_ROWS, nr);
            set_reg(CFG_LON_ORIGIN, ph == 1 ? 32'(-23592960) :
                    ph == 2 ? 32'd23592960 : 32'($signed($urandom_range(0, 2000000)) - 1000000));
            set_reg(CFG_LAT_ORIGIN, ph == 1 ? 32'd5898240 :
                    ph == 2 ? 32'(-5898240) : 32'($signed($urandom_range(0, 400000)) - 200000));
            set_reg(CFG_LON_STEP, ph == 0 ? 32'd8388607 : ph == 1 ? 32'd1 :
                    $urandom_range(1000, 300000));
            set_reg(CFG_LAT_STEP, ph == 0 ? 32'(-8388608) : ph == 1 ? 32'd8388607 :
                    ph == 3 ? 32'd1 : 32'($signed($urandom_range(0, 600000)) - 300000));
            set_reg(CFG_LON_WRAP, ph % 2);
            if (ph == 7) calm = 1;
            rand_phase(50, nc, nr);
            drain();
        end
        // writes to cells beyond the current size, plus raw config index 7
        set_reg(3'd7, $urandom);
        put_cell(1, 127, 127, $urandom, 1);

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/gbs_pkg.sv
rtl/gbs_req_if.sv
rtl/gbs_rsp_if.sv
rtl/gbs_cfg_if.sv
rtl/gbs_ram.sv
rtl/gbs_div.sv
rtl/grid_bilinear_sampler_top.sv
dv/grid_bilinear_sampler_top_tb.sv
